/* design/pwfr_pkg.sv */
// ============================================================================
// pwfr_pkg: shared types and constants of the pulse width frame relay
// Holds the configuration register map, reset values and the result record.
// ============================================================================
package pwfr_pkg;

    // Default frame geometry.
    localparam int BITS_PER_FRAME_DEF = 8;
    localparam int COUNT_WIDTH_DEF    = 8;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // Width of the output bit field.
    localparam int FRAME_BITS_W = 8;

    // Configuration register map.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_TICK_LIMIT = 3'd0,
        CFG_LEAD_TICKS       = 3'd1,
        CFG_SHORT_TICKS      = 3'd2,
        CFG_LONG_TICKS       = 3'd3,
        CFG_ACTIVE_LOW       = 3'd4
    } t_cfg_reg;

    // Register reset values.
    localparam logic [7:0] FRAME_TICK_LIMIT_RST = 8'd110;
    localparam logic [3:0] LEAD_TICKS_RST       = 4'd9;
    localparam logic [3:0] SHORT_TICKS_RST      = 4'd2;
    localparam logic [3:0] LONG_TICKS_RST       = 4'd6;
    localparam logic       ACTIVE_LOW_RST       = 1'b0;

    // Current configuration as seen by the engine.
    typedef struct packed {
        logic [7:0] frame_tick_limit;
        logic [3:0] lead_ticks;
        logic [3:0] short_ticks;
        logic [3:0] long_ticks;
        logic       active_low;
    } t_cfg;

    // One result request.
    typedef struct packed {
        logic                    out_level;
        logic                    frame_done;
        logic [FRAME_BITS_W-1:0] frame_bits;
        logic                    frame_timeout;
    } t_result;

endpackage

/* design/pwfr_engine.sv */
// ============================================================================
// pwfr_engine: receiver and transmitter state of the frame relay
// Decodes one line sample per step and advances the pulse transmitter.
// ============================================================================
module pwfr_engine #(
    parameter int BITS_PER_FRAME = pwfr_pkg::BITS_PER_FRAME_DEF,
    parameter int COUNT_WIDTH    = pwfr_pkg::COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_line_level,
    input  pwfr_pkg::t_cfg    i_cfg,
    output pwfr_pkg::t_result o_result
);

    localparam int IDX_W = $clog2(BITS_PER_FRAME + 1);
    localparam int CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
    localparam int FRAME_EXT_W = pwfr_pkg::FRAME_BITS_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
    localparam logic [IDX_W-1:0]       IDX_LAST = IDX_W'(BITS_PER_FRAME);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEAD = 2'd1,
        PH_LOW  = 2'd2,
        PH_HIGH = 2'd3
    } t_phase;

    t_phase                    r_rx_phase, n_rx_phase;
    logic [COUNT_WIDTH-1:0]    r_rx_tick, n_rx_tick;
    logic [IDX_W-1:0]          r_rx_idx, n_rx_idx;
    logic [COUNT_WIDTH-1:0]    r_low, n_low;
    logic [COUNT_WIDTH-1:0]    r_high, n_high;
    logic [BITS_PER_FRAME-1:0] r_rx_bits, n_rx_bits;
    t_phase                    r_tx_phase, n_tx_phase;
    logic [3:0]                r_tx_count, n_tx_count;
    logic [IDX_W-1:0]          r_tx_idx, n_tx_idx;
    logic [BITS_PER_FRAME-1:0] r_tx_bits, n_tx_bits;
    logic                      r_tx_level, n_tx_level;

    logic                                   active;
    logic                                   done;
    logic                                   timeout;
    logic [BITS_PER_FRAME-1:0]              bit_mask;
    logic [IDX_W-1:0]                       rx_idx_inc;
    logic [BITS_PER_FRAME+FRAME_EXT_W-1:0]  bits_ext;
    logic [BITS_PER_FRAME-1:0]              tx_shift;
    logic                                   tx_bit;
    logic                                   tx_expired;

    assign active     = i_line_level ^ i_cfg.active_low;
    assign bit_mask   = BITS_PER_FRAME'(1) << r_rx_idx;
    assign rx_idx_inc = r_rx_idx + IDX_W'(1);
    assign tx_shift   = r_tx_bits >> r_tx_idx;
    assign tx_bit     = tx_shift[0];
    assign tx_expired = (r_tx_count <= 4'd1);

    // Receiver: lead pulse, then low and high phase per bit, with a frame timeout.
    always_comb begin
        n_rx_phase = r_rx_phase;
        n_rx_tick  = r_rx_tick;
        n_rx_idx   = r_rx_idx;
        n_low      = r_low;
        n_high     = r_high;
        n_rx_bits  = r_rx_bits;
        done       = 1'b0;
        timeout    = 1'b0;
        priority if (r_rx_phase == PH_IDLE) begin
            if (active) begin
                n_rx_phase = PH_LEAD;
                n_rx_tick  = COUNT_WIDTH'(1);
                n_rx_idx   = '0;
                n_low      = '0;
                n_high     = '0;
                n_rx_bits  = '0;
            end
        end else if (CMP_W'(r_rx_tick) >= CMP_W'(i_cfg.frame_tick_limit)) begin
            n_rx_tick  = (r_rx_tick == CNT_MAX) ? r_rx_tick : r_rx_tick + COUNT_WIDTH'(1);
            n_rx_phase = PH_IDLE;
            timeout    = 1'b1;
        end else begin
            n_rx_tick = (r_rx_tick == CNT_MAX) ? r_rx_tick : r_rx_tick + COUNT_WIDTH'(1);
            unique case (r_rx_phase)
                PH_LEAD: begin
                    if (!active) begin
                        n_rx_phase = PH_LOW;
                    end
                end
                PH_LOW: begin
                    if (active) begin
                        n_rx_phase = PH_HIGH;
                    end else begin
                        n_low = (r_low == CNT_MAX) ? r_low : r_low + COUNT_WIDTH'(1);
                    end
                end
                PH_HIGH: begin
                    if (active) begin
                        n_high = (r_high == CNT_MAX) ? r_high : r_high + COUNT_WIDTH'(1);
                    end else begin
                        // The inactive tick that ends the high phase decides the bit.
                        if (r_high > r_low) begin
                            n_rx_bits = r_rx_bits & ~bit_mask;
                        end else begin
                            n_rx_bits = r_rx_bits | bit_mask;
                        end
                        n_low    = '0;
                        n_high   = '0;
                        n_rx_idx = rx_idx_inc;
                        if (rx_idx_inc >= IDX_LAST) begin
                            n_rx_phase = PH_IDLE;
                            done       = 1'b1;
                        end else begin
                            n_rx_phase = PH_LOW;
                        end
                    end
                end
                PH_IDLE: begin
                end
            endcase
        end
    end

    // Transmitter: a completed frame reloads it, otherwise it runs its phases.
    always_comb begin
        n_tx_phase = r_tx_phase;
        n_tx_count = r_tx_count;
        n_tx_idx   = r_tx_idx;
        n_tx_bits  = r_tx_bits;
        n_tx_level = r_tx_level;
        if (done) begin
            n_tx_bits  = n_rx_bits;
            n_tx_idx   = '0;
            n_tx_count = i_cfg.lead_ticks;
            n_tx_phase = PH_HIGH;
            n_tx_level = 1'b1;
        end else begin
            unique case (r_tx_phase)
                PH_LOW: begin
                    if (tx_expired) begin
                        n_tx_count = tx_bit ? i_cfg.short_ticks : i_cfg.long_ticks;
                        n_tx_idx   = r_tx_idx + IDX_W'(1);
                        n_tx_level = 1'b1;
                        n_tx_phase = PH_HIGH;
                    end else begin
                        n_tx_count = r_tx_count - 4'd1;
                    end
                end
                PH_HIGH: begin
                    if (tx_expired) begin
                        n_tx_count = '0;
                        n_tx_level = 1'b0;
                        if (r_tx_idx >= IDX_LAST) begin
                            n_tx_phase = PH_IDLE;
                        end else begin
                            n_tx_count = tx_bit ? i_cfg.long_ticks : i_cfg.short_ticks;
                            n_tx_phase = PH_LOW;
                        end
                    end else begin
                        n_tx_count = r_tx_count - 4'd1;
                    end
                end
                PH_IDLE, PH_LEAD: begin
                end
            endcase
        end
    end

    // Result of this step; frame bits show only when a frame completes.
    assign bits_ext = {{FRAME_EXT_W{1'b0}}, n_rx_bits};

    always_comb begin
        o_result.out_level     = n_tx_level;
        o_result.frame_done    = done;
        o_result.frame_bits    = done ? bits_ext[FRAME_EXT_W-1:0] : '0;
        o_result.frame_timeout = timeout;
    end

    // State registers advance once per accepted sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_phase <= PH_IDLE;
            r_rx_tick  <= '0;
            r_rx_idx   <= '0;
            r_low      <= '0;
            r_high     <= '0;
            r_rx_bits  <= '0;
            r_tx_phase <= PH_IDLE;
            r_tx_count <= '0;
            r_tx_idx   <= '0;
            r_tx_bits  <= '0;
            r_tx_level <= 1'b0;
        end else if (i_step) begin
            r_rx_phase <= n_rx_phase;
            r_rx_tick  <= n_rx_tick;
            r_rx_idx   <= n_rx_idx;
            r_low      <= n_low;
            r_high     <= n_high;
            r_rx_bits  <= n_rx_bits;
            r_tx_phase <= n_tx_phase;
            r_tx_count <= n_tx_count;
            r_tx_idx   <= n_tx_idx;
            r_tx_bits  <= n_tx_bits;
            r_tx_level <= n_tx_level;
        end
    end

endmodule

/* design/pwfr_outbuf.sv */
// ============================================================================
// pwfr_outbuf: result register with a skid stage
// Holds results while the output side stalls and keeps the input side moving until the skid stage fills.
// ============================================================================
module pwfr_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pwfr_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_full,
    output logic              o_valid,
    output pwfr_pkg::t_result o_result
);

    logic              r_out_valid;
    logic              r_skid_valid;
    pwfr_pkg::t_result r_out;
    pwfr_pkg::t_result r_skid;
    logic              take;

    assign take = r_out_valid && !i_stall;

    // Control: the output register refills from the skid stage first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (take || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= i_push;
                end
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_result;
            end
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

/* design/pulse_width_frame_relay.sv */
// Output: a result request is registered in the result register when its sample is accepted.
// Throughput: one sample per cycle while o_stall is low; the engine state advances once per accepted sample.
// A skid stage behind the result register holds one result during an output stall; o_stall rises when it is full.
// Reset: synchronous, active low; clears receiver and transmitter state, loads the
// configuration defaults and empties the result register and the skid stage.
// ============================================================================
// pulse_width_frame_relay: pulse width frame receiver and retransmitter
// Decodes pulse width frames (eight bits by default) from line samples and resends them.
// ============================================================================
module pulse_width_frame_relay #(
    parameter int BITS_PER_FRAME = pwfr_pkg::BITS_PER_FRAME_DEF,
    parameter int COUNT_WIDTH    = pwfr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Sample channel.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_line_level,
    // Result channel.
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_out_level,
    output logic                                o_frame_done,
    output logic [pwfr_pkg::FRAME_BITS_W-1:0]   o_frame_bits,
    output logic                                o_frame_timeout,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [pwfr_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [pwfr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    pwfr_pkg::t_cfg    r_cfg;
    pwfr_pkg::t_result step_result;
    pwfr_pkg::t_result out_result;
    logic              accept;
    logic              buf_full;

    assign accept  = i_valid && !buf_full;
    assign o_stall = buf_full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_tick_limit <= pwfr_pkg::FRAME_TICK_LIMIT_RST;
            r_cfg.lead_ticks       <= pwfr_pkg::LEAD_TICKS_RST;
            r_cfg.short_ticks      <= pwfr_pkg::SHORT_TICKS_RST;
            r_cfg.long_ticks       <= pwfr_pkg::LONG_TICKS_RST;
            r_cfg.active_low       <= pwfr_pkg::ACTIVE_LOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pwfr_pkg::CFG_FRAME_TICK_LIMIT: r_cfg.frame_tick_limit <= i_cfg_data;
                pwfr_pkg::CFG_LEAD_TICKS:       r_cfg.lead_ticks       <= i_cfg_data[3:0];
                pwfr_pkg::CFG_SHORT_TICKS:      r_cfg.short_ticks      <= i_cfg_data[3:0];
                pwfr_pkg::CFG_LONG_TICKS:       r_cfg.long_ticks       <= i_cfg_data[3:0];
                pwfr_pkg::CFG_ACTIVE_LOW:       r_cfg.active_low       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Receiver and transmitter.
    pwfr_engine #(
        .BITS_PER_FRAME (BITS_PER_FRAME),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (accept),
        .i_line_level (i_line_level),
        .i_cfg        (r_cfg),
        .o_result     (step_result)
    );

    // Result register and skid stage.
    pwfr_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_result (step_result),
        .i_stall  (i_stall),
        .o_full   (buf_full),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_out_level     = out_result.out_level;
    assign o_frame_done    = out_result.frame_done;
    assign o_frame_bits    = out_result.frame_bits;
    assign o_frame_timeout = out_result.frame_timeout;

endmodule
